@@ hw/rtl/atps_pkg.sv @@
package atps_pkg;

    localparam int MaxAxesDefault = 8;
    localparam int IdW = 11;
    localparam int TimeW = 32;
    localparam int PeriodW = 16;
    localparam int ResultCap = 8;

    localparam logic [1:0] CmdPoll  = 2'd0;
    localparam logic [1:0] CmdReg   = 2'd1;
    localparam logic [1:0] CmdUnreg = 2'd2;
    localparam logic [1:0] CmdAck   = 2'd3;

    localparam logic [1:0] ResReq    = 2'd0;
    localparam logic [1:0] ResNone   = 2'd1;
    localparam logic [1:0] ResStatus = 2'd2;

    localparam logic [2:0] KindRetry = 3'd0;
    localparam logic [2:0] KindPos   = 3'd1;
    localparam logic [2:0] KindSpd   = 3'd2;
    localparam logic [2:0] KindSts   = 3'd3;
    localparam logic [2:0] KindProt  = 3'd4;

    localparam logic [2:0] StOk      = 3'd0;
    localparam logic [2:0] StInvalid = 3'd1;
    localparam logic [2:0] StDup     = 3'd2;
    localparam logic [2:0] StMissing = 3'd3;
    localparam logic [2:0] StFull    = 3'd4;

    localparam logic [2:0] CfgPos   = 3'd0;
    localparam logic [2:0] CfgSpd   = 3'd1;
    localparam logic [2:0] CfgSts   = 3'd2;
    localparam logic [2:0] CfgProt  = 3'd3;
    localparam logic [2:0] CfgRetry = 3'd4;
    localparam logic [2:0] CfgTlm   = 3'd5;
    localparam logic [2:0] CfgTx    = 3'd6;
    localparam logic [2:0] CfgInit  = 3'd7;

    // entry word: id, five due times, retries
    localparam int EntryW = IdW + 5 * TimeW + 2;

    typedef struct packed {
        logic [1:0]  command;
        logic [10:0] can_id;
        logic [31:0] now_ms;
        logic [7:0]  tx_sent;
    } t_in_beat;

    typedef struct packed {
        logic [1:0]  result_type;
        logic [10:0] request_can_id;
        logic [2:0]  request_kind;
        logic [2:0]  op_status;
        logic        last;
    } t_out_beat;

    typedef struct packed {
        logic [IdW-1:0]   id;
        logic [TimeW-1:0] retry_due;
        logic [TimeW-1:0] pos_due;
        logic [TimeW-1:0] spd_due;
        logic [TimeW-1:0] sts_due;
        logic [TimeW-1:0] prot_due;
        logic [1:0]       retries;
    } t_entry;

    typedef enum logic [3:0] {
        S_IDLE, S_SCAN_RD, S_SCAN_CHK, S_POLL_RD, S_POLL_CHK,
        S_SHIFT_RD, S_SHIFT_WR, S_EMIT
    } t_state;

    function automatic logic is_due(input logic [31:0] due, input logic [31:0] now);
        logic [31:0] d;
        d = now - due;
        return ~d[31];
    endfunction

endpackage

@@ hw/rtl/axis_telemetry_poll_scheduler_core.sv @@
// axis telemetry poll scheduler
// input channel i_in_valid/o_in_ready carries one command beat: poll, register,
// unregister or response-policy ack. output channel o_out_valid/i_out_ready
// returns result beats; the final beat of a command has last set.
// register, unregister and ack give one status beat; a poll gives one to
// eight request beats or one "nothing sent" beat.
// the axis table lives in one ram with registered read, one entry per axis.
// a lookup reads and then compares one entry at a time (S_SCAN_RD, S_SCAN_CHK);
// a register of id 0 is answered without a lookup.
// unregister then moves each later entry down one place, a read and a write each.
// a poll visits entries round-robin, up to 4*count visits or until the budget
// is spent; an empty table or zero budget goes straight to its one beat.
// one command is worked at a time; the next is taken the cycle after the
// final beat is accepted.
// a stalled receiver holds the poll at the next hit; no beat is dropped.
// the config channel i_cfg_valid/o_cfg_ready is always ready; writes are
// expected only while idle.
// reset clears count, round-robin pointer and config to defaults; table
// contents are undefined until registered, no clearing pass is needed.
module axis_telemetry_poll_scheduler_core #(
    parameter int MaxAxes = atps_pkg::MaxAxesDefault
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  atps_pkg::t_in_beat i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output atps_pkg::t_out_beat o_out_data,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [2:0]         i_cfg_index,
    input  logic [15:0]        i_cfg_data
);
    import atps_pkg::*;

    localparam int AW = (MaxAxes > 1) ? $clog2(MaxAxes) : 1;
    localparam int CW = $clog2(MaxAxes + 1);
    localparam int VW = $clog2(4 * MaxAxes + 1);
    localparam int RamDepth = (MaxAxes > 1) ? MaxAxes : 2;

    logic [15:0] r_pos_p, r_spd_p, r_sts_p, r_prot_p, r_retry_p;
    logic [3:0]  r_tlm_b;
    logic [7:0]  r_tx_b;
    logic [1:0]  r_init_r;

    t_state r_state, n_state;
    t_in_beat r_cmd, n_cmd;
    logic [CW-1:0] r_count, n_count;
    logic [AW-1:0] r_rr, n_rr;
    logic [AW-1:0] r_idx, n_idx;
    logic [VW-1:0] r_visits, n_visits;
    logic [3:0] r_budget, n_budget;
    logic [3:0] r_sent, n_sent;
    t_out_beat r_out, n_out;
    logic r_out_v, n_out_v;
    t_out_beat r_pend, n_pend;
    logic r_pend_v, n_pend_v;

    logic we;
    logic [AW-1:0] waddr, raddr;
    t_entry wdata, rdata;
    logic [EntryW-1:0] rdata_w;

    atps_ram #(.Width(EntryW), .Depth(RamDepth)) u_ram (
        .i_clk  (i_clk),
        .i_we   (we),
        .i_waddr(waddr),
        .i_wdata(wdata),
        .i_raddr(raddr),
        .o_rdata(rdata_w)
    );
    assign rdata = t_entry'(rdata_w);

    assign o_cfg_ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos_p <= 16'd10; r_spd_p <= 16'd25; r_sts_p <= 16'd50;
            r_prot_p <= 16'd200; r_retry_p <= 16'd500; r_tlm_b <= 4'd8;
            r_tx_b <= 8'd24; r_init_r <= 2'd3;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CfgPos:   r_pos_p <= i_cfg_data;
                CfgSpd:   r_spd_p <= i_cfg_data;
                CfgSts:   r_sts_p <= i_cfg_data;
                CfgProt:  r_prot_p <= i_cfg_data;
                CfgRetry: r_retry_p <= i_cfg_data;
                CfgTlm:   r_tlm_b <= i_cfg_data[3:0];
                CfgTx:    r_tx_b <= i_cfg_data[7:0];
                CfgInit:  r_init_r <= i_cfg_data[1:0];
                default: ;
            endcase
        end
    end

    assign o_in_ready = (r_state == S_IDLE) && !r_out_v;
    assign o_out_valid = r_out_v;
    assign o_out_data = r_out;

    logic [7:0] tx_room;
    logic [7:0] bud8;
    logic [AW-1:0] idx_inc;
    logic [CW-1:0] idx_ext, count_m1;
    logic [VW-1:0] max_visits;
    logic out_free;

    always_comb begin
        tx_room = (i_in_data.tx_sent >= r_tx_b) ? 8'd0
                : r_tx_b - i_in_data.tx_sent;
        bud8 = ({4'd0, r_tlm_b} < tx_room) ? {4'd0, r_tlm_b} : tx_room;
        if (bud8 > 8'(ResultCap)) bud8 = 8'(ResultCap);
        idx_ext = CW'(r_idx);
        count_m1 = r_count - CW'(1);
        idx_inc = r_idx + AW'(1);
        max_visits = VW'({r_count, 2'b00});
        out_free = !r_out_v || i_out_ready;
    end

    logic hit;
    logic [2:0] hit_kind;
    t_entry hit_entry;

    always_comb begin
        hit = 1'b1;
        hit_kind = KindRetry;
        hit_entry = rdata;
        if (rdata.retries != 2'd0 && is_due(rdata.retry_due, r_cmd.now_ms)) begin
            hit_entry.retries = rdata.retries - 2'd1;
            hit_entry.retry_due = r_cmd.now_ms + 32'(r_retry_p);
        end else if (is_due(rdata.pos_due, r_cmd.now_ms)) begin
            hit_kind = KindPos;
            hit_entry.pos_due = r_cmd.now_ms + 32'(r_pos_p);
        end else if (is_due(rdata.spd_due, r_cmd.now_ms)) begin
            hit_kind = KindSpd;
            hit_entry.spd_due = r_cmd.now_ms + 32'(r_spd_p);
        end else if (is_due(rdata.sts_due, r_cmd.now_ms)) begin
            hit_kind = KindSts;
            hit_entry.sts_due = r_cmd.now_ms + 32'(r_sts_p);
        end else if (is_due(rdata.prot_due, r_cmd.now_ms)) begin
            hit_kind = KindProt;
            hit_entry.prot_due = r_cmd.now_ms + 32'(r_prot_p);
        end else begin
            hit = 1'b0;
        end
    end

    always_comb begin
        n_state = r_state; n_cmd = r_cmd; n_count = r_count; n_rr = r_rr;
        n_idx = r_idx; n_visits = r_visits; n_budget = r_budget; n_sent = r_sent;
        n_out = r_out; n_out_v = r_out_v; n_pend = r_pend; n_pend_v = r_pend_v;
        we = 1'b0; waddr = r_idx; raddr = r_idx; wdata = rdata;
        if (r_out_v && i_out_ready) n_out_v = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid && o_in_ready) begin
                    n_cmd = i_in_data;
                    n_idx = '0;
                    n_visits = '0;
                    n_sent = '0;
                    n_pend = '0;
                    n_pend_v = 1'b0;
                    n_pend.result_type = ResStatus;
                    if (i_in_data.command == CmdPoll) begin
                        if (r_count == '0 || bud8 == '0) begin
                            n_pend.result_type = ResNone;
                            n_state = S_EMIT;
                        end else begin
                            n_budget = bud8[3:0];
                            if (CW'(r_rr) >= r_count) n_rr = '0;
                            n_state = S_POLL_RD;
                        end
                    end else if (i_in_data.command == CmdReg &&
                                 i_in_data.can_id == '0) begin
                        n_pend.op_status = StInvalid;
                        n_state = S_EMIT;
                    end else begin
                        n_state = S_SCAN_RD;
                    end
                end
            end
            S_SCAN_RD: begin
                n_state = S_SCAN_CHK;
            end
            S_SCAN_CHK: begin
                if (idx_ext < r_count && rdata.id == r_cmd.can_id) begin
                    case (r_cmd.command)
                        CmdReg: begin
                            n_pend.op_status = StDup;
                            n_state = S_EMIT;
                        end
                        CmdAck: begin
                            we = 1'b1;
                            wdata.retries = 2'd0;
                            n_pend.op_status = StOk;
                            n_state = S_EMIT;
                        end
                        default: begin
                            n_pend.op_status = StOk;
                            n_state = S_SHIFT_RD;
                        end
                    endcase
                end else if (idx_ext + CW'(1) < r_count) begin
                    n_idx = idx_inc;
                    n_state = S_SCAN_RD;
                end else if (r_cmd.command == CmdReg) begin
                    if (r_count >= CW'(MaxAxes)) begin
                        n_pend.op_status = StFull;
                    end else begin
                        we = 1'b1;
                        waddr = AW'(r_count);
                        wdata.id = r_cmd.can_id;
                        wdata.retry_due = r_cmd.now_ms;
                        wdata.pos_due = r_cmd.now_ms;
                        wdata.spd_due = r_cmd.now_ms;
                        wdata.sts_due = r_cmd.now_ms;
                        wdata.prot_due = r_cmd.now_ms;
                        wdata.retries = r_init_r;
                        n_count = r_count + CW'(1);
                        n_pend.op_status = StOk;
                    end
                    n_state = S_EMIT;
                end else begin
                    n_pend.op_status = StMissing;
                    n_state = S_EMIT;
                end
            end
            S_SHIFT_RD: begin
                if (idx_ext + CW'(1) < r_count) begin
                    raddr = idx_inc;
                    n_state = S_SHIFT_WR;
                end else begin
                    n_count = count_m1;
                    if (CW'(r_rr) >= count_m1) n_rr = '0;
                    n_state = S_EMIT;
                end
            end
            S_SHIFT_WR: begin
                we = 1'b1;
                waddr = r_idx;
                n_idx = idx_inc;
                n_state = S_SHIFT_RD;
            end
            S_POLL_RD: begin
                if (r_sent >= r_budget || r_visits >= max_visits) begin
                    if (!r_pend_v) begin
                        n_pend = '0;
                        n_pend.result_type = ResNone;
                    end
                    n_state = S_EMIT;
                end else begin
                    raddr = r_rr;
                    n_idx = r_rr;
                    n_state = S_POLL_CHK;
                end
            end
            S_POLL_CHK: begin
                // a hit with a beat still pending waits for the output register
                if (!hit || !r_pend_v || out_free) begin
                    n_visits = r_visits + VW'(1);
                    n_rr = (idx_ext + CW'(1) >= r_count) ? '0 : idx_inc;
                    n_state = S_POLL_RD;
                    if (hit) begin
                        we = 1'b1;
                        wdata = hit_entry;
                        if (r_pend_v) begin
                            n_out = r_pend;
                            n_out_v = 1'b1;
                        end
                        n_pend = '0;
                        n_pend.result_type = ResReq;
                        n_pend.request_can_id = rdata.id;
                        n_pend.request_kind = hit_kind;
                        n_pend_v = 1'b1;
                        n_sent = r_sent + 4'd1;
                    end
                end
            end
            S_EMIT: begin
                if (out_free) begin
                    n_out = r_pend;
                    n_out.last = 1'b1;
                    n_out_v = 1'b1;
                    n_pend_v = 1'b0;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_rr <= '0;
            r_out_v <= 1'b0;
            r_pend_v <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_rr <= n_rr;
            r_out_v <= n_out_v;
            r_pend_v <= n_pend_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd <= n_cmd;
        r_idx <= n_idx;
        r_visits <= n_visits;
        r_budget <= n_budget;
        r_sent <= n_sent;
        r_out <= n_out;
        r_pend <= n_pend;
    end
endmodule

@@ hw/rtl/atps_ram.sv @@
module atps_ram #(
    parameter int Width = 8,
    parameter int Depth = 8
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(Depth)-1:0] i_waddr,
    input  logic [Width-1:0]         i_wdata,
    input  logic [$clog2(Depth)-1:0] i_raddr,
    output logic [Width-1:0]         o_rdata
);
    logic [Width-1:0] r_mem [Depth];
    logic [Width-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

@@ hw/rtl/atps_checker.sv @@
module atps_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                o_in_ready,
    input logic                o_out_valid,
    input logic                i_out_ready,
    input atps_pkg::t_out_beat o_out_data
);
    import atps_pkg::*;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("output beat dropped while stalled");

    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_data.last |-> !o_in_ready)
        else $error("input taken mid result");

    a_status_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.result_type != ResReq |-> o_out_data.last)
        else $error("status beat not last");

    a_type_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out_data.result_type != 2'd3)
        else $error("bad result type");
endmodule

bind axis_telemetry_poll_scheduler_core atps_checker u_atps_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_in_ready (o_in_ready),
    .o_out_valid(o_out_valid),
    .i_out_ready(i_out_ready),
    .o_out_data (o_out_data)
);

@@ tb/sv/axis_telemetry_poll_scheduler_core_test.sv @@
module axis_telemetry_poll_scheduler_core_test;
    timeunit 1ns;
    timeprecision 1ps;

    import atps_pkg::*;

    typedef logic [15:0] t_regset [8];

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_ready;
    t_in_beat in_data = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    t_out_beat out_data;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [2:0] cfg_index = '0;
    logic [15:0] cfg_data = '0;

    always #5 i_clk = ~i_clk;

    axis_telemetry_poll_scheduler_core DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    // scheduler shadow state
    logic [15:0] per_pos, per_spd, per_sts, per_prot, per_rty;
    logic [3:0]  tlm_budget;
    logic [7:0]  tx_budget;
    logic [1:0]  init_retries;
    logic [10:0] tab_id [8];
    logic [31:0] due_pos [8], due_spd [8], due_sts [8], due_prot [8], due_rty [8];
    logic [1:0]  tab_rtr [8];
    int axis_cnt = 0;
    int rr_idx = 0;

    t_in_beat  cmd_queue [$];
    t_out_beat want_beats [$];
    int errors = 0;
    int cmds_taken = 0;
    int beats_seen = 0;
    int req_beats = 0;
    logic in_fire = 1'b0;
    int send_gap = 0;
    int recv_stall = 0;
    int hold_cnt = 0;
    bit hold_start = 0;
    bit no_idle = 0;
    logic [31:0] cur_now = 32'd0;

    function automatic bit reached(logic [31:0] due, logic [31:0] now);
        logic [31:0] d;
        d = now - due;
        return !d[31];
    endfunction

    function automatic int lookup(logic [10:0] id);
        for (int i = 0; i < axis_cnt; i++) begin
            if (tab_id[i] == id) return i;
        end
        return -1;
    endfunction

    task automatic push_beat(logic [1:0] rt, logic [10:0] id, logic [2:0] kind,
                             logic [2:0] st);
        t_out_beat b;
        b.result_type = rt;
        b.request_can_id = id;
        b.request_kind = kind;
        b.op_status = st;
        b.last = 1'b0;
        want_beats = {want_beats, b};
    endtask

    task automatic sched_step(t_in_beat c);
        int sent, tries, bud, tx_room, i, f;
        logic [2:0] st;
        sent = 0;
        tries = 0;
        st = StOk;
        if (c.command == CmdPoll) begin
            tx_room = (c.tx_sent >= tx_budget) ? 0
                      : int'(tx_budget) - int'(c.tx_sent);
            bud = (int'(tlm_budget) < tx_room) ? int'(tlm_budget) : tx_room;
            if (bud > 8) bud = 8;
            if (axis_cnt != 0 && bud != 0) begin
                if (rr_idx >= axis_cnt) rr_idx = 0;
                while (sent < bud && tries < axis_cnt * 4) begin
                    i = rr_idx;
                    rr_idx = (rr_idx + 1) % axis_cnt;
                    tries++;
                    if (tab_rtr[i] > 0 && reached(due_rty[i], c.now_ms)) begin
                        tab_rtr[i]--;
                        due_rty[i] = c.now_ms + 32'(per_rty);
                        push_beat(ResReq, tab_id[i], KindRetry, StOk);
                        sent++;
                    end else if (reached(due_pos[i], c.now_ms)) begin
                        due_pos[i] = c.now_ms + 32'(per_pos);
                        push_beat(ResReq, tab_id[i], KindPos, StOk);
                        sent++;
                    end else if (reached(due_spd[i], c.now_ms)) begin
                        due_spd[i] = c.now_ms + 32'(per_spd);
                        push_beat(ResReq, tab_id[i], KindSpd, StOk);
                        sent++;
                    end else if (reached(due_sts[i], c.now_ms)) begin
                        due_sts[i] = c.now_ms + 32'(per_sts);
                        push_beat(ResReq, tab_id[i], KindSts, StOk);
                        sent++;
                    end else if (reached(due_prot[i], c.now_ms)) begin
                        due_prot[i] = c.now_ms + 32'(per_prot);
                        push_beat(ResReq, tab_id[i], KindProt, StOk);
                        sent++;
                    end
                end
            end
            if (sent == 0) push_beat(ResNone, '0, KindRetry, StOk);
        end else begin
            f = lookup(c.can_id);
            if (c.command == CmdReg) begin
                if (c.can_id == 0) st = StInvalid;
                else if (f >= 0) st = StDup;
                else if (axis_cnt >= 8) st = StFull;
                else begin
                    tab_id[axis_cnt] = c.can_id;
                    due_pos[axis_cnt] = c.now_ms;
                    due_spd[axis_cnt] = c.now_ms;
                    due_sts[axis_cnt] = c.now_ms;
                    due_prot[axis_cnt] = c.now_ms;
                    due_rty[axis_cnt] = c.now_ms;
                    tab_rtr[axis_cnt] = init_retries;
                    axis_cnt++;
                end
            end else if (c.command == CmdUnreg) begin
                if (f < 0) st = StMissing;
                else begin
                    for (i = f; i + 1 < axis_cnt; i++) begin
                        tab_id[i] = tab_id[i+1];
                        due_pos[i] = due_pos[i+1];
                        due_spd[i] = due_spd[i+1];
                        due_sts[i] = due_sts[i+1];
                        due_prot[i] = due_prot[i+1];
                        due_rty[i] = due_rty[i+1];
                        tab_rtr[i] = tab_rtr[i+1];
                    end
                    axis_cnt--;
                    if (rr_idx >= axis_cnt) rr_idx = 0;
                end
            end else begin
                if (f < 0) st = StMissing;
                else tab_rtr[f] = 2'd0;
            end
            push_beat(ResStatus, '0, KindRetry, st);
        end
        want_beats[want_beats.size()-1].last = 1'b1;
    endtask

    // input driver
    always @(posedge i_clk) in_fire <= in_valid && in_ready;

    always @(negedge i_clk) begin
        if (!in_valid || in_fire) begin
            if (in_fire && !no_idle && $urandom_range(0, 3) == 0)
                send_gap = $urandom_range(1, 7);
            if (send_gap > 0) begin
                send_gap--;
                in_valid <= 1'b0;
            end else if (cmd_queue.size() > 0) begin
                in_data <= cmd_queue.pop_front();
                in_valid <= 1'b1;
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    // result receiver
    always @(negedge i_clk) begin
        if (hold_start) begin
            hold_start = 0;
            hold_cnt = 400;
        end
        if (hold_cnt > 0) begin
            hold_cnt--;
            out_ready <= 1'b0;
        end else if (recv_stall > 0) begin
            recv_stall--;
            out_ready <= 1'b0;
        end else begin
            out_ready <= 1'b1;
            if (!no_idle && $urandom_range(0, 5) == 0) recv_stall = $urandom_range(1, 7);
        end
    end

    always @(posedge i_clk) begin
        t_out_beat w;
        if (i_rst_n && in_valid && in_ready) begin
            sched_step(in_data);
            cmds_taken++;
        end
        if (i_rst_n && out_valid && out_ready) begin
            beats_seen++;
            if (want_beats.size() == 0) begin
                $error("unexpected beat %p", out_data);
                errors++;
            end else begin
                w = want_beats.pop_front();
                if (w.result_type == ResReq) req_beats++;
                if (out_data.result_type !== w.result_type) begin
                    $error("result_type exp %0d got %0d", w.result_type, out_data.result_type);
                    errors++;
                end
                if (out_data.request_can_id !== w.request_can_id) begin
                    $error("request_can_id exp %0d got %0d", w.request_can_id,
                           out_data.request_can_id);
                    errors++;
                end
                if (out_data.request_kind !== w.request_kind) begin
                    $error("request_kind exp %0d got %0d", w.request_kind,
                           out_data.request_kind);
                    errors++;
                end
                if (out_data.op_status !== w.op_status) begin
                    $error("op_status exp %0d got %0d", w.op_status, out_data.op_status);
                    errors++;
                end
                if (out_data.last !== w.last) begin
                    $error("last exp %0d got %0d", w.last, out_data.last);
                    errors++;
                end
            end
        end
    end

    function automatic t_in_beat mk(logic [1:0] cmd, logic [10:0] id, logic [31:0] now,
                                    logic [7:0] tx);
        t_in_beat b;
        b.command = cmd;
        b.can_id = id;
        b.now_ms = now;
        b.tx_sent = tx;
        return b;
    endfunction

    function automatic void queue_cmd(t_in_beat b);
        cmd_queue = {cmd_queue, b};
    endfunction

    task automatic drain();
        while (cmd_queue.size() > 0 || in_valid || want_beats.size() > 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
    endtask

    task automatic write_regs(t_regset v);
        for (int r = 0; r < 8; r++) begin
            @(negedge i_clk);
            cfg_valid = 1'b1;
            cfg_index = 3'(r);
            cfg_data = v[r];
            do @(posedge i_clk); while (!cfg_ready);
            case (3'(r))
                CfgPos:   per_pos = v[r];
                CfgSpd:   per_spd = v[r];
                CfgSts:   per_sts = v[r];
                CfgProt:  per_prot = v[r];
                CfgRetry: per_rty = v[r];
                CfgTlm:   tlm_budget = v[r][3:0];
                CfgTx:    tx_budget = v[r][7:0];
                CfgInit:  init_retries = v[r][1:0];
                default: ;
            endcase
        end
        @(negedge i_clk);
        cfg_valid = 1'b0;
    endtask

    task automatic random_cmds(int n);
        logic [1:0] cmd;
        logic [10:0] id;
        logic [7:0] tx;
        int pick;
        for (int k = 0; k < n; k++) begin
            pick = $urandom_range(0, 99);
            cmd = (pick < 50) ? CmdPoll : (pick < 75) ? CmdReg : (pick < 90) ? CmdUnreg : CmdAck;
            pick = $urandom_range(0, 9);
            id = (pick < 8) ? 11'($urandom_range(1, 10)) : (pick == 8) ? 11'd0 : 11'($urandom);
            cur_now += ($urandom_range(0, 19) == 0) ? $urandom : $urandom_range(0, 60);
            tx = ($urandom_range(0, 9) < 7) ? 8'($urandom_range(0, 30)) : 8'($urandom);
            queue_cmd(mk(cmd, id, cur_now, tx));
        end
    endtask

    initial begin
        t_regset rs;
        per_pos = 16'd10;
        per_spd = 16'd25;
        per_sts = 16'd50;
        per_prot = 16'd200;
        per_rty = 16'd500;
        tlm_budget = 4'd8;
        tx_budget = 8'd24;
        init_retries = 2'd3;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        queue_cmd(mk(CmdPoll, 11'd0, 32'd0, 8'd0));
        queue_cmd(mk(CmdReg, 11'd0, 32'd100, 8'd0));
        queue_cmd(mk(CmdReg, 11'd1, 32'd100, 8'd0));
        queue_cmd(mk(CmdReg, 11'd2047, 32'd100, 8'd0));
        for (int k = 3; k <= 8; k++) queue_cmd(mk(CmdReg, 11'(k), 32'd100, 8'd0));
        queue_cmd(mk(CmdReg, 11'd9, 32'd100, 8'd0));
        queue_cmd(mk(CmdReg, 11'd5, 32'd100, 8'd0));
        queue_cmd(mk(CmdPoll, 11'd0, 32'd100, 8'd0));
        queue_cmd(mk(CmdPoll, 11'd0, 32'd100, 8'd255));
        queue_cmd(mk(CmdPoll, 11'd0, 32'd100, 8'd20));
        queue_cmd(mk(CmdAck, 11'd3, 32'd100, 8'd0));
        queue_cmd(mk(CmdAck, 11'd100, 32'd100, 8'd0));
        queue_cmd(mk(CmdUnreg, 11'd1500, 32'd100, 8'd0));
        queue_cmd(mk(CmdUnreg, 11'd1, 32'd100, 8'd0));
        queue_cmd(mk(CmdUnreg, 11'd8, 32'd100, 8'd0));
        queue_cmd(mk(CmdPoll, 11'd0, 32'hFFFF_FFFF, 8'd0));
        queue_cmd(mk(CmdPoll, 11'd0, 32'h8000_0063, 8'd3));
        queue_cmd(mk(CmdPoll, 11'd0, 32'h8000_0064, 8'd0));
        queue_cmd(mk(CmdPoll, 11'd0, 32'h8000_0064, 8'd24));
        drain();

        // fast periods, full tx, long receiver hold
        rs = '{16'd1, 16'd1, 16'd1, 16'd1, 16'd1, 16'd8, 16'd255, 16'd3};
        write_regs(rs);
        hold_start = 1;
        random_cmds(50);
        drain();

        // zero periods, saturated telemetry budget, no retries
        rs = '{16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd15, 16'd255, 16'd0};
        write_regs(rs);
        random_cmds(50);
        drain();

        rs = '{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd1, 16'd1, 16'd2};
        write_regs(rs);
        cur_now = 32'hFFFF_FF00;
        random_cmds(50);
        drain();

        rs = '{16'd10, 16'd25, 16'd50, 16'd200, 16'd500, 16'd0, 16'd0, 16'd1};
        write_regs(rs);
        random_cmds(25);
        drain();

        for (int r = 0; r < 8; r++) rs[r] = 16'($urandom);
        for (int r = 0; r < 5; r++) rs[r] = 16'($urandom_range(1, 80));
        write_regs(rs);
        random_cmds(65);
        drain();

        for (int r = 0; r < 5; r++) rs[r] = 16'($urandom_range(1, 40));
        rs[5] = 16'($urandom_range(1, 8));
        rs[6] = 16'($urandom_range(8, 255));
        rs[7] = 16'($urandom_range(0, 3));
        write_regs(rs);
        no_idle = 1;
        random_cmds(65);
        drain();

        $display("covered %0d commands over 7 register settings, %0d result beats checked",
                 cmds_taken, beats_seen);
        $display("%0d of them telemetry requests", req_beats);
        if (errors == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule

@@ filelist.f @@
hw/rtl/atps_pkg.sv
hw/rtl/atps_ram.sv
hw/rtl/axis_telemetry_poll_scheduler_core.sv
hw/rtl/atps_checker.sv
tb/sv/axis_telemetry_poll_scheduler_core_test.sv
